/* rtl/rss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the record selection sorter
// Record layout, sort key codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int GRADE_W   = 9;
    localparam int CREDITS_W = 16;
    localparam int NAME_W    = 64;
    localparam int KEY_W     = 2;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    // Byte address of the sort key register.
    localparam logic [PADDR_W-1:0] ADDR_SORT_KEY = 3'd0;

    // Sort key codes; the unused code sorts by name.
    localparam logic [KEY_W-1:0] KEY_GRADE   = 2'd0;
    localparam logic [KEY_W-1:0] KEY_CREDITS = 2'd1;
    localparam logic [KEY_W-1:0] KEY_NAME    = 2'd2;

    typedef struct packed {
        logic [GRADE_W-1:0]   grade;
        logic [CREDITS_W-1:0] credits;
        logic [NAME_W-1:0]    name;
    } t_record;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_END,
        ST_SWAP_HI,
        ST_SWAP_LO,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

endpackage

/* rtl/rss_key_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_key_cmp: shared key compare unit
// Picks the configured key from two records and reports whether the
// candidate's key is strictly greater than the current maximum's key.
// ----------------------------------------------------------------------------
module rss_key_cmp (
    input  logic [rss_pkg::KEY_W-1:0] i_sort_key,
    input  rss_pkg::t_record          i_cand,
    input  rss_pkg::t_record          i_best,
    output logic                      o_greater
);
    import rss_pkg::*;

    always_comb begin
        case (i_sort_key)
            KEY_GRADE: begin
                o_greater = (i_cand.grade > i_best.grade);
            end
            KEY_CREDITS: begin
                o_greater = (i_cand.credits > i_best.credits);
            end
            default: begin
                // Packed names compare like a byte-wise string compare.
                o_greater = (i_cand.name > i_best.name);
            end
        endcase
    end

endmodule

/* rtl/record_selection_sort.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_selection_sort: loads a set of records and emits it sorted
// Records are stored until the one marked last, then sorted in place by
// selection sort with one memory read port and one key compare unit, and
// emitted in ascending key order.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  input   | in        | i_in_valid / o_in_stall   | grade, credits, name, last
//  output  | out       | o_out_valid / i_out_stall | grade, credits, name, last, ovf
//  config  | in        | APB psel/penable/pready   | sort_key at byte address 0
//
// Loading takes one record per cycle. Each sort pass over an unsorted prefix
// reads every record of the prefix once and then swaps the maximum into the
// prefix's last slot. Emitting reads each record from the single registered
// read port before loading it into the output register, and waits on stalls.
// Reset is synchronous and active low and empties the store; no clearing pass.
// The input is stalled from the last record of a set until its final result
// has been loaded into the output register; that result may still wait there.
// ----------------------------------------------------------------------------
module record_selection_sort #(
    parameter int MAX_RECORDS = 64,
    parameter int NAME_CHARS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rss_pkg::GRADE_W-1:0]     i_grade_hundredths,
    input  logic [rss_pkg::CREDITS_W-1:0]   i_credits,
    input  logic [rss_pkg::NAME_W-1:0]      i_name_bytes,
    input  logic                            i_last_record,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rss_pkg::GRADE_W-1:0]     o_out_grade,
    output logic [rss_pkg::CREDITS_W-1:0]   o_out_credits,
    output logic [rss_pkg::NAME_W-1:0]      o_out_name,
    output logic                            o_out_last,
    output logic                            o_overflow,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rss_pkg::PADDR_W-1:0]     paddr,
    input  logic [rss_pkg::DATA_W-1:0]      pwdata,
    output logic [rss_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import rss_pkg::*;

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] r_sort_key;
    logic             cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == ADDR_SORT_KEY[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key <= KEY_GRADE;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_sort_key <= pwdata[KEY_W-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(DATA_W-KEY_W){1'b0}}, r_sort_key} : '0;

    // ------------------------------------------------------------------
    // Name normalization: keep NAME_CHARS bytes, zero all after the first NUL
    // ------------------------------------------------------------------
    logic [NAME_W-1:0] norm_name;

    always_comb begin : name_norm
        logic       ended;
        logic [7:0] b;
        ended     = 1'b0;
        norm_name = '0;
        for (int k = 0; k < 8; k++) begin
            b = i_name_bytes[NAME_W-1-8*k -: 8];
            if (k >= NAME_CHARS || b == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                norm_name[NAME_W-1-8*k -: 8] = b;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic [AW-1:0]    r_j;       // read address during a scan
    logic [AW-1:0]    r_tail;    // last slot of the unsorted prefix
    logic [AW-1:0]    r_big;     // first index holding the maximum so far
    logic [AW-1:0]    r_k;       // emit index
    logic             r_cmp_vld;
    logic [AW-1:0]    r_cmp_idx;
    t_record          r_best;
    t_record          r_tail_rec;
    t_record          r_rd_data;
    t_record          r_mem [MAX_RECORDS];
    logic             r_out_valid;
    t_record          r_out_rec;
    logic             r_out_last;
    logic             r_out_ovf;

    // ------------------------------------------------------------------
    // Shared signals
    // ------------------------------------------------------------------
    logic          in_accept;
    logic          store_full;
    logic [CW-1:0] count_after;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] last_idx;
    logic          out_free;
    logic          greater;
    logic          take;
    t_record       in_rec;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign store_full  = (r_count == CW'(MAX_RECORDS));
    assign count_after = store_full ? r_count : r_count + CW'(1);
    assign count_m1    = r_count - CW'(1);
    assign last_idx    = count_m1[AW-1:0];
    assign out_free    = !r_out_valid || !i_out_stall;

    assign in_rec.grade   = i_grade_hundredths;
    assign in_rec.credits = i_credits;
    assign in_rec.name    = norm_name;

    rss_key_cmp u_cmp (
        .i_sort_key (r_sort_key),
        .i_cand     (r_rd_data),
        .i_best     (r_best),
        .o_greater  (greater)
    );

    // The first record of a pass seeds the maximum; later ones replace it
    // only when strictly greater, so the first index of the maximum wins.
    assign take = r_cmp_vld && ((r_cmp_idx == '0) || greater);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_accept && i_last_record) begin
                    n_state = (count_after >= CW'(2)) ? ST_SCAN : ST_EMIT_RD;
                end
            end
            ST_SCAN: begin
                if (r_j == r_tail) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_SWAP_HI;
            end
            ST_SWAP_HI: begin
                n_state = ST_SWAP_LO;
            end
            ST_SWAP_LO: begin
                n_state = (r_tail == AW'(1)) ? ST_EMIT_RD : ST_SCAN;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    n_state = (r_k == last_idx) ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory and handshake control
    // ------------------------------------------------------------------
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_record       mem_wd;
    logic [AW-1:0] mem_ra;
    logic          out_load;

    always_comb begin
        mem_we     = 1'b0;
        mem_wa     = r_count[AW-1:0];
        mem_wd     = in_rec;
        mem_ra     = r_j;
        out_load   = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                mem_we     = in_accept && !store_full;
            end
            ST_SWAP_HI: begin
                mem_we = 1'b1;
                mem_wa = r_big;
                mem_wd = r_tail_rec;
            end
            ST_SWAP_LO: begin
                mem_we = 1'b1;
                mem_wa = r_tail;
                mem_wd = r_best;
            end
            ST_EMIT_RD: begin
                mem_ra = r_k;
            end
            ST_EMIT_LD: begin
                mem_ra   = r_k;
                out_load = out_free;
            end
            default: begin
                mem_ra = r_j;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_j       <= '0;
            r_k       <= '0;
            r_tail    <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            case (r_state)
                ST_LOAD: begin
                    if (in_accept) begin
                        r_count <= count_after;
                        if (store_full) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_record) begin
                            r_j    <= '0;
                            r_k    <= '0;
                            r_tail <= AW'(count_after - CW'(1));
                        end
                    end
                end
                ST_SCAN: begin
                    r_j <= r_j + AW'(1);
                end
                ST_SWAP_LO: begin
                    r_j    <= '0;
                    r_tail <= r_tail - AW'(1);
                end
                ST_EMIT_LD: begin
                    if (out_free) begin
                        r_k <= r_k + AW'(1);
                        if (r_k == last_idx) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_j <= r_j;
                end
            endcase
        end
    end

    // Scan datapath: running maximum and the record found in the tail slot.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            r_cmp_idx <= r_j;
        end
        if (take) begin
            r_best <= r_rd_data;
            r_big  <= r_cmp_idx;
        end
        if (r_cmp_vld && r_cmp_idx == r_tail) begin
            r_tail_rec <= r_rd_data;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rec  <= r_rd_data;
            r_out_last <= (r_k == last_idx);
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_grade   = r_out_rec.grade;
    assign o_out_credits = r_out_rec.credits;
    assign o_out_name    = r_out_rec.name;
    assign o_out_last    = r_out_last;
    assign o_overflow    = r_out_ovf;

endmodule

/* rtl/rss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_checker: port-level checks of the record selection sorter
// Watches the handshakes of both channels, the stall behavior around
// the end of a set and the idle state after reset.
// ----------------------------------------------------------------------------
module rss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_last_record,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [rss_pkg::NAME_W-1:0]    o_out_name,
    input logic [rss_pkg::GRADE_W-1:0]   o_out_grade
);
    import rss_pkg::*;

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its name and grade.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_name) && $stable(o_out_grade))
        else $error("output payload changed while stalled");

    // The last record of a set ends loading, so the input must stall next.
    a_sort_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_record |=> o_in_stall)
        else $error("input not stalled after the last record of a set");

    // After reset the block is empty and ready to load.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind record_selection_sort rss_checker u_rss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_last_record (i_last_record),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_name    (o_out_name),
    .o_out_grade   (o_out_grade)
);
